// ----- rtl/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

endpackage

// ----- rtl/lkvc_if.sv -----
interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [KEY_W-1:0]  lookup_key;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

// ----- rtl/lkvc_store.sv -----
// Key/value memory: one write port, one read port, registered read data.
module lkvc_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [IW-1:0]                waddr_i,
  input  logic [lkvc_pkg::KEY_W-1:0]   wkey_i,
  input  logic [lkvc_pkg::DATA_W-1:0]  wdata_i,
  input  logic [IW-1:0]                raddr_i,
  output logic [lkvc_pkg::KEY_W-1:0]   rkey_o,
  output logic [lkvc_pkg::DATA_W-1:0]  rdata_o
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0]  key_mem  [DEPTH];
  logic [DATA_W-1:0] data_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      data_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o  <= key_mem[raddr_i];
    rdata_o <= data_mem[raddr_i];
  end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Fully associative key/value cache with least-recently-used replacement.
//
// req (sink): one transfer carries operation (get/put), lookup_key and
//   write_value. A get returns one transfer on rsp; a put returns nothing.
// rsp (source): found and read_value; read_value is all ones on a miss.
// cfg_we_i/cfg_wdata_i: writes the capacity (0 acts as 1, above DEPTH acts
//   as DEPTH) and empties the cache. Write only while the block is idle.
//
// Each item walks the key memory one entry per cycle through a single
// comparator (registered read), then the update state writes key/data for
// a put and re-ranks all ages in parallel for a put or a get hit. req.ready
// is high only while idle, so no new item is taken until the current one is
// done; the scan over the one memory read port sets how long that takes. A
// get result is loaded into the output register in the update state.
// The result sits in an output register; if rsp stalls, the block still
// takes the next request and finishes it, holding only in the update cycle
// of a later get until the earlier result has been transferred.
// Reset empties the cache and sets the capacity to 16; memory contents are
// not cleared, valid bits guard every read.
module lru_key_value_cache #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lkvc_req_if.sink                     req,
  lkvc_rsp_if.source                   rsp,
  input  logic                         cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata_i
);
  import lkvc_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW = IW;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  // Item being worked on
  logic              op_put_q, op_put_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] val_q, val_d;

  // Scan read/compare pipeline
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic [IW-1:0]     cmp_idx_q;
  logic              cmp_vld_q;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_data;

  // Scan results
  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_slot_q, hit_slot_d;
  logic [DATA_W-1:0] hit_data_q, hit_data_d;
  logic [AW-1:0]     hit_age_q, hit_age_d;
  logic              free_found_q, free_found_d;
  logic [IW-1:0]     free_slot_q, free_slot_d;
  logic [IW-1:0]     victim_q, victim_d;

  // Entry state
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic [AW-1:0]     age_q [DEPTH];
  logic [AW-1:0]     age_d [DEPTH];
  logic [CW-1:0]     count_q, count_d;
  logic [CAP_W-1:0]  cap_q, cap_d;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic              out_found_q, out_found_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;

  logic              accept;
  logic [CW-1:0]     limit;
  logic              full;
  logic              upd_go;
  logic              do_touch;
  logic              do_fill;
  logic [IW-1:0]     upd_slot;
  logic [CW-1:0]     touch_age;
  logic [CW-1:0]     oldest_age;
  logic              cmp_live;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);

  assign rsp.valid      = out_vld_q;
  assign rsp.found      = out_found_q;
  assign rsp.read_value = out_value_q;

  // Effective capacity
  always_comb begin
    if (cap_q == '0) begin
      limit = CW'(1);
    end else if (32'(cap_q) > DEPTH) begin
      limit = CW'(DEPTH);
    end else begin
      limit = CW'(cap_q);
    end
  end

  assign full       = (count_q >= limit);
  assign oldest_age = count_q - CW'(1);

  // A get waits in update while an older result is still unread.
  assign upd_go   = op_put_q || !out_vld_q || rsp.ready;
  assign do_touch = (state_q == S_UPD) && upd_go && (op_put_q || hit_q);
  assign do_fill  = do_touch && op_put_q && !hit_q && !full;

  always_comb begin
    if (hit_q) begin
      upd_slot  = hit_slot_q;
      touch_age = CW'(hit_age_q);
    end else if (full) begin
      upd_slot  = victim_q;
      touch_age = oldest_age;
    end else begin
      upd_slot  = free_slot_q;
      touch_age = count_q;
    end
  end

  lkvc_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_touch && op_put_q),
    .waddr_i (upd_slot),
    .wkey_i  (key_q),
    .wdata_i (val_q),
    .raddr_i (rd_idx_q),
    .rkey_o  (rd_key),
    .rdata_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    op_put_d = op_put_q;
    key_d    = key_q;
    val_d    = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_put_d = (req.operation == OP_PUT);
          key_d    = req.lookup_key;
          val_d    = req.write_value;
          rd_idx_d = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_idx_d = rd_idx_q + IW'(1);
        if (rd_idx_q == IW'(DEPTH - 1)) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Compare stage: one entry per cycle
  assign cmp_live = cmp_vld_q && valid_q[cmp_idx_q];

  always_comb begin
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    hit_data_d   = hit_data_q;
    hit_age_d    = hit_age_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    victim_d     = victim_q;
    if (accept) begin
      hit_d        = 1'b0;
      free_found_d = 1'b0;
    end else if (cmp_vld_q) begin
      if (cmp_live && (rd_key == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = cmp_idx_q;
        hit_data_d = rd_data;
        hit_age_d  = age_q[cmp_idx_q];
      end
      if (!valid_q[cmp_idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_slot_d  = cmp_idx_q;
      end
      if (cmp_live && (CW'(age_q[cmp_idx_q]) == oldest_age)) begin
        victim_d = cmp_idx_q;
      end
    end
  end

  // Update: rank ages, fill slot, apply capacity writes, load result
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    cap_d   = cap_q;
    for (int j = 0; j < DEPTH; j++) begin
      age_d[j] = age_q[j];
      if (do_touch) begin
        if (IW'(j) == upd_slot) begin
          age_d[j] = '0;
        end else if (valid_q[j] && (CW'(age_q[j]) < touch_age)) begin
          age_d[j] = age_q[j] + AW'(1);
        end
      end
    end
    if (do_fill) begin
      valid_d[upd_slot] = 1'b1;
      count_d           = count_q + CW'(1);
    end
    if (cfg_we_i) begin
      cap_d   = cfg_wdata_i;
      valid_d = '0;
      count_d = '0;
    end
  end

  always_comb begin
    out_vld_d   = out_vld_q && !rsp.ready;
    out_found_d = out_found_q;
    out_value_d = out_value_q;
    if ((state_q == S_UPD) && !op_put_q && upd_go) begin
      out_vld_d   = 1'b1;
      out_found_d = hit_q;
      out_value_d = hit_q ? hit_data_q : MISS_VALUE;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      cap_q        <= CAP_RESET;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmp_vld_q    <= (state_q == S_SCAN);
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      cap_q        <= cap_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    cmp_idx_q   <= rd_idx_q;
    op_put_q    <= op_put_d;
    key_q       <= key_d;
    val_q       <= val_d;
    hit_slot_q  <= hit_slot_d;
    hit_data_q  <= hit_data_d;
    hit_age_q   <= hit_age_d;
    free_slot_q <= free_slot_d;
    victim_q    <= victim_d;
    out_found_q <= out_found_d;
    out_value_q <= out_value_d;
    for (int j = 0; j < DEPTH; j++) begin
      age_q[j] <= age_d[j];
    end
  end

  // Checks
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("entry count out of step with valid bits");

  a_count_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= limit)
    else $error("entry count above capacity");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (count_q == '0) && (valid_q == '0))
    else $error("capacity write did not empty the cache");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && !hit_q)
    else $error("accepted request did not start a scan");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  // Block geometry and run budget. The drain pause after the last transfer
  // covers one full put plus some margin before the capacity may be
  // rewritten.
  localparam int unsigned DEPTH        = 16;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 3 + 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned PHASE_ITEMS  = 178;
  localparam int unsigned N_PHASES     = 10;
  localparam int unsigned IDLE_PCT     = 32;

  typedef struct {
    op_e                      op;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] data;
  } cache_req_t;

  typedef struct {
    logic                     found;
    logic signed [DATA_W-1:0] data;
  } cache_rsp_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CAP_W-1:0]     cfg_wdata_i;

  lkvc_req_if req_ch();
  lkvc_rsp_if rsp_ch();

  lru_key_value_cache #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the cache: valid bits, keys, data, recency ranks
  // (0 = most recent; valid entries always hold ranks 0..count-1).
  // ---------------------------------------------------------------------
  logic [CAP_W-1:0]  cap_reg;
  logic              ent_valid [DEPTH];
  logic [KEY_W-1:0]  ent_key   [DEPTH];
  logic [DATA_W-1:0] ent_data  [DEPTH];
  int unsigned       ent_age   [DEPTH];
  int unsigned       ent_count;

  cache_req_t  req_backlog  [$];  // requests waiting for the driver
  cache_rsp_t  due_lookups  [$];  // get results not yet seen on rsp
  cache_req_t  cur_req;           // request currently offered on req

  int unsigned req_idle_pct = IDLE_PCT;
  int unsigned rsp_idle_pct = IDLE_PCT;
  int          phase_no     = 0;

  int unsigned n_gets, n_puts, n_hits, n_evictions, n_results, n_cap_writes;
  int unsigned n_errors;
  int unsigned cycle_cnt;

  function automatic void clear_cache();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_data[i]  = '0;
      ent_age[i]   = 0;
    end
    ent_count = 0;
  endfunction

  // Zero acts as one, anything above DEPTH acts as DEPTH.
  function automatic int unsigned eff_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  // Move a slot to rank 0; every valid entry that was more recent ages by one.
  function automatic void promote(int unsigned slot);
    int unsigned rank;
    rank = ent_age[slot];
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (ent_valid[i] && i != slot && ent_age[i] < rank) ent_age[i]++;
    end
    ent_age[slot] = 0;
  endfunction

  // Apply one request to the shadow cache. Returns 1 when a get produced a
  // result (placed in res); puts return 0.
  function automatic bit lru_access(input cache_req_t it, output cache_rsp_t res);
    int          hit;
    int unsigned slot;
    int unsigned oldest;
    bit          any;
    hit    = -1;
    slot   = 0;
    oldest = 0;
    any    = 1'b0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (hit < 0 && ent_valid[i] && ent_key[i] == it.key) hit = i;
    end
    res.found = 1'b0;
    res.data  = MISS_VALUE;

    if (it.op == OP_GET) begin
      n_gets++;
      if (hit >= 0) begin
        res.found = 1'b1;
        res.data  = ent_data[hit];
        promote(hit);
        n_hits++;
      end
      return 1'b1;
    end

    n_puts++;
    if (hit >= 0) begin
      ent_data[hit] = it.data;
      promote(hit);
      return 1'b0;
    end

    if (ent_count >= eff_capacity()) begin
      // full: reuse the least recent entry (largest rank)
      for (int unsigned i = 0; i < DEPTH; i++) begin
        if (ent_valid[i] && (!any || ent_age[i] > oldest)) begin
          oldest = ent_age[i];
          slot   = i;
          any    = 1'b1;
        end
      end
      n_evictions++;
    end else begin
      for (int unsigned i = 0; i < DEPTH; i++) begin
        if (!ent_valid[i]) begin
          slot = i;
          break;
        end
      end
      ent_valid[slot] = 1'b1;
      ent_age[slot]   = ent_count;
      ent_count++;
    end
    ent_key[slot]  = it.key;
    ent_data[slot] = it.data;
    promote(slot);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt,
               due_lookups.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Request driver: offers backlog items with random gaps, holds the item
  // while ready is low, and runs the shadow cache on every transfer so the
  // expected get results line up in transfer order.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_rsp_t res;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (lru_access(cur_req, res)) due_lookups.push_back(res);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
          cur_req = req_backlog.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.operation   <= cur_req.op;
          req_ch.lookup_key  <= cur_req.key;
          req_ch.write_value <= cur_req.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response monitor: checks each transfer against the oldest due result.
  // In two chosen phases it drops ready for a long stretch while the driver
  // keeps offering, so the block's output register fills and req stalls.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_rsp_t  want;
    static int   held_in   = -1;
    static int unsigned hold_left = 0;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (due_lookups.size() == 0) begin
          $error("rsp transfer with no get outstanding: found=%0b read_value=%0d",
                 rsp_ch.found, rsp_ch.read_value);
          n_errors++;
        end else begin
          want = due_lookups.pop_front();
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, rsp_ch.found);
            n_errors++;
          end
          if (rsp_ch.read_value !== want.data) begin
            $error("read_value: expected %0d, got %0d", want.data, rsp_ch.read_value);
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if ((phase_no == 5 || phase_no == 9) && held_in != phase_no) begin
        held_in   = phase_no;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic queue_get(input logic [KEY_W-1:0] key);
    cache_req_t it;
    it.op   = OP_GET;
    it.key  = key;
    it.data = $urandom();
    req_backlog.push_back(it);
  endtask

  task automatic queue_put(input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] data);
    cache_req_t it;
    it.op   = OP_PUT;
    it.key  = key;
    it.data = data;
    req_backlog.push_back(it);
  endtask

  // Wait until every request has transferred and every get result has come
  // back, then let a trailing put finish inside the block.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || req_ch.valid || due_lookups.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Capacity write; the block empties itself, so does the shadow copy.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = cap;
    clear_cache();
    phase_no++;
    n_cap_writes++;
  endtask

  // Keys come mostly from a pool a little larger than the capacity, so gets
  // hit, puts update, and misses evict; the rest are fresh random keys.
  task automatic queue_random_phase(input int unsigned n);
    logic [KEY_W-1:0] pool [$];
    int unsigned      cap;
    int unsigned      pool_size;
    cache_req_t       it;
    cap       = eff_capacity();
    pool_size = cap + $urandom_range(cap + 1, 1);
    repeat (pool_size) begin
      case ($urandom_range(15))
        0:       pool.push_back('0);
        1:       pool.push_back('1);
        2:       pool.push_back({1'b1, {(KEY_W-1){1'b0}}});
        3:       pool.push_back({1'b0, {(KEY_W-1){1'b1}}});
        default: pool.push_back($urandom());
      endcase
    end
    repeat (n) begin
      it.op   = ($urandom_range(1) == 0) ? OP_GET : OP_PUT;
      it.key  = ($urandom_range(99) < 82) ? pool[$urandom_range(pool.size() - 1)]
                                          : $urandom();
      it.data = $urandom();
      req_backlog.push_back(it);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [N_PHASES];
    logic [CAP_W-1:0] cap;

    // known values on every input from time zero
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = 1'b0;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    rsp_ch.ready       = 1'b0;

    cap_reg = CAP_RESET;
    clear_cache();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed, reset capacity: miss on empty, extreme keys and values,
    // a hit whose value equals the miss pattern, a plain miss, an update.
    queue_get(32'h0000_0000);
    queue_put(32'h8000_0000, 32'h7FFF_FFFF);
    queue_put(32'h7FFF_FFFF, 32'h8000_0000);
    queue_put(32'h0000_0000, 32'h0000_0000);
    queue_put(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_get(32'h8000_0000);
    queue_get(32'h7FFF_FFFF);
    queue_get(32'h0000_0000);
    queue_get(32'hFFFF_FFFF);
    queue_get(32'h0000_0001);
    queue_put(32'hFFFF_FFFF, 32'h0000_0001);
    queue_get(32'hFFFF_FFFF);
    wait_drained();

    // Capacity two: touching A makes B the victim when C arrives.
    write_capacity(5'd2);
    queue_put(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_put(32'h5A5A_5A5A, 32'hA5A5_A5A5);
    queue_get(32'hA5A5_A5A5);
    queue_put(32'h0000_0001, 32'h0000_0002);
    queue_get(32'h5A5A_5A5A);
    queue_get(32'hA5A5_A5A5);
    queue_get(32'h0000_0001);
    wait_drained();

    // Same capacity again still empties the cache.
    write_capacity(5'd2);
    queue_get(32'hA5A5_A5A5);
    wait_drained();

    // Random phases over capacities 1, 0 (acts as 1), 31 and 17 (act as 16),
    // 16 itself, small and mid sizes. Phase 4 runs with no idling at all.
    caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd3, 5'd8, 5'd0, 5'd0, 5'd12};
    for (int k = 0; k < N_PHASES; k++) begin
      cap = (k == 7 || k == 8) ? CAP_W'($urandom_range(15, 2)) : caps[k];
      write_capacity(cap);
      req_idle_pct = (k == 4) ? 0 : IDLE_PCT;
      rsp_idle_pct = (k == 4) ? 0 : IDLE_PCT;
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    $display("Covered %0d gets (%0d hits) and %0d puts (%0d evictions), %0d results",
             n_gets, n_hits, n_puts, n_evictions, n_results);
    $display("over %0d capacity writes incl. 0, 1, 16, 17 and 31; %0d mismatches",
             n_cap_writes, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
